/* rtl/mfek_pkg.sv */
// Package for the Edmonds-Karp max-flow core: sizes, sequencer states.
// No dependencies.
`timescale 1ns / 1ps
package mfek_pkg;
  localparam int VERTICES = 8;
  localparam int VBITS = 3;
  localparam int CAP_BITS = 16;
  localparam int RES_BITS = 17;
  localparam int FLOW_BITS = 19;
  localparam int ABITS = 2 * VBITS;
  localparam int DEPTH = VERTICES * VERTICES;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_COPY_RD,
    ST_COPY_WR,
    ST_BFS_INIT,
    ST_BFS_POP,
    ST_BFS_SCAN,
    ST_BFS_CHECK,
    ST_MIN_RD,
    ST_MIN_ACC,
    ST_UPD_FWD,
    ST_UPD_REV,
    ST_UPD_WR,
    ST_DONE
  } state_t;
endpackage

/* rtl/max_flow_edmonds_karp_core.sv */
// Top level of the Edmonds-Karp max-flow core.
// Depends on mfek_pkg.
//
// channel | direction | handshake        | fields
// input   | in        | start / busy     | from_vertex to_vertex capacity
//         |           |                  | source_vertex sink_vertex last
// result  | out       | done (one cycle) | max_flow status
//
// A matrix entry without last is written as it is accepted; busy stays low.
// An item with last writes its entry, then busy rises while a run copies the
// matrix (ST_COPY_RD then ST_COPY_WR per entry), then repeats a breadth-first
// search (a pop state, then a scan that reads each residual in the row of the
// dequeued vertex) and a path walk, ST_MIN_RD and ST_MIN_ACC per edge for the
// bottleneck and ST_UPD_FWD, ST_UPD_REV and ST_UPD_WR per edge for the update.
// With source equal to sink, done follows the accepting edge directly. done
// pulses once at the end; the receiver cannot stall. Reset clears the capacity
// matrix with a sweep over all DEPTH entries during which busy is high.
`timescale 1ns / 1ps
module max_flow_edmonds_karp_core import mfek_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [VBITS-1:0]     from_vertex,
  input  logic [VBITS-1:0]     to_vertex,
  input  logic [CAP_BITS-1:0]  capacity,
  input  logic [VBITS-1:0]     source_vertex,
  input  logic [VBITS-1:0]     sink_vertex,
  input  logic                 last,
  output logic                 done,
  output logic [FLOW_BITS-1:0] max_flow,
  output logic                 status
);

  // Capacity matrix and residual matrix, each with a write port and a separate read port.
  logic [CAP_BITS-1:0] cap_mem [DEPTH];
  logic [RES_BITS-1:0] res_mem [DEPTH];
  logic [CAP_BITS-1:0] cap_rd;
  logic [RES_BITS-1:0] res_rd;

  state_t state, state_next;
  logic clearing;
  logic [ABITS:0] clr_cnt;
  logic [ABITS:0] cnt;                 // copy sweep index
  logic [VBITS-1:0] src, dst;
  logic [VERTICES-1:0] visited;
  logic [VBITS-1:0] parent [VERTICES];
  logic [VBITS-1:0] queue [VERTICES];
  logic [VBITS:0] head, tail;
  logic [VBITS-1:0] u, v;
  logic [VBITS:0] scan;                // column being scanned
  logic [VBITS:0] steps;
  logic [RES_BITS-1:0] bneck;
  logic [FLOW_BITS-1:0] flow;

  logic accept;
  assign accept = start && !busy;
  assign busy = clearing || (state != ST_IDLE);

  // Memory address and write controls.
  logic cap_we, res_we;
  logic [ABITS-1:0] cap_addr, res_addr;
  logic [CAP_BITS-1:0] cap_wd;
  logic [RES_BITS-1:0] res_wd;
  logic [VBITS-1:0] pv;
  assign pv = parent[v];

  always_comb begin
    cap_we = 1'b0;
    cap_addr = cnt[ABITS-1:0];
    cap_wd = capacity;
    if (clearing) begin
      cap_we = 1'b1;
      cap_addr = clr_cnt[ABITS-1:0];
      cap_wd = '0;
    end else if (accept) begin
      cap_we = 1'b1;
      cap_addr = {from_vertex, to_vertex};
    end
  end

  always_comb begin
    res_we = 1'b0;
    res_wd = res_rd;
    res_addr = {u, scan[VBITS-1:0]};
    case (state)
      ST_COPY_WR: begin
        res_we = 1'b1;
        res_addr = cnt[ABITS-1:0];
        res_wd = {1'b0, cap_rd};
      end
      ST_MIN_RD:  res_addr = {pv, v};
      ST_UPD_FWD: res_addr = {pv, v};
      ST_UPD_REV: begin
        // write the lowered forward entry, read the reverse entry next
        res_we = 1'b1;
        res_addr = {pv, v};
        res_wd = res_rd - bneck;
      end
      ST_UPD_WR: begin
        res_we = 1'b1;
        res_addr = {v, pv};
        res_wd = res_rd + bneck;
      end
      default: res_addr = {u, scan[VBITS-1:0]};
    endcase
  end

  // In ST_UPD_WR the reverse entry must already have been read, so in ST_UPD_REV
  // the read address is switched from the write address to the reverse entry.
  logic [ABITS-1:0] res_raddr;
  always_comb begin
    res_raddr = res_addr;
    if (state == ST_UPD_REV) res_raddr = {v, pv};
  end

  always_ff @(posedge clk) begin
    if (cap_we) cap_mem[cap_addr] <= cap_wd;
    cap_rd <= cap_mem[cnt[ABITS-1:0]];
    if (res_we) res_mem[res_addr] <= res_wd;
    res_rd <= res_mem[res_raddr];
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && last) begin
          if (source_vertex == sink_vertex) state_next = ST_DONE;
          else state_next = ST_COPY_RD;
        end
      end
      ST_COPY_RD: state_next = ST_COPY_WR;
      ST_COPY_WR: state_next = (cnt == DEPTH - 1) ? ST_BFS_INIT : ST_COPY_RD;
      ST_BFS_INIT: state_next = ST_BFS_POP;
      ST_BFS_POP: state_next = (head < tail) ? ST_BFS_SCAN : ST_BFS_CHECK;
      ST_BFS_SCAN: state_next = (scan == VERTICES) ? ST_BFS_POP : ST_BFS_SCAN;
      ST_BFS_CHECK: state_next = visited[dst] ? ST_MIN_RD : ST_DONE;
      ST_MIN_RD: state_next = (v == src || steps == VERTICES) ? ST_UPD_FWD : ST_MIN_ACC;
      ST_MIN_ACC: state_next = ST_MIN_RD;
      ST_UPD_FWD: state_next = (v == src || steps == VERTICES) ? ST_BFS_INIT : ST_UPD_REV;
      ST_UPD_REV: state_next = ST_UPD_WR;
      ST_UPD_WR: state_next = ST_UPD_FWD;
      ST_DONE: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    done = (state == ST_DONE);
  end
  assign max_flow = flow;

  // Scan: res_rd holds residual[u][scan-1], read in the cycle before.
  logic [VBITS-1:0] col_prev;
  logic scan_hit;
  assign col_prev = scan[VBITS-1:0] - 1'b1;
  assign scan_hit = (scan != 0) && !visited[col_prev] && (res_rd != 0)
                    && (tail < VERTICES);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      clearing <= 1'b1;
      clr_cnt <= '0;
      status <= 1'b0;
      flow <= '0;
      visited <= '0;
    end else begin
      state <= state_next;
      if (clearing) begin
        clr_cnt <= clr_cnt + 1'b1;
        if (clr_cnt == DEPTH - 1) clearing <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          cnt <= '0;
          src <= source_vertex;
          dst <= sink_vertex;
          flow <= '0;
          status <= (source_vertex == sink_vertex);
        end
        ST_COPY_WR: cnt <= cnt + 1'b1;
        ST_BFS_INIT: begin
          // clear the marks and mark the source in one write
          visited <= VERTICES'(1) << src;
          parent[src] <= src;
          queue[0] <= src;
          head <= '0;
          tail <= (VBITS+1)'(1);
        end
        ST_BFS_POP: begin
          if (head < tail) begin
            u <= queue[head[VBITS-1:0]];
            head <= head + 1'b1;
          end
          scan <= '0;
        end
        ST_BFS_SCAN: begin
          if (scan_hit) begin
            queue[tail[VBITS-1:0]] <= col_prev;
            parent[col_prev] <= u;
            visited[col_prev] <= 1'b1;
            tail <= tail + 1'b1;
          end
          if (scan != VERTICES) scan <= scan + 1'b1;
        end
        ST_BFS_CHECK: begin
          v <= dst;
          steps <= '0;
          bneck <= '1;
        end
        ST_MIN_RD: begin
          if (v == src || steps == VERTICES) begin
            v <= dst;
            steps <= '0;
          end
        end
        ST_MIN_ACC: begin
          if (res_rd < bneck) bneck <= res_rd;
          v <= pv;
          steps <= steps + 1'b1;
        end
        ST_UPD_FWD: begin
          if (v == src || steps == VERTICES) flow <= flow + FLOW_BITS'(bneck);
        end
        ST_UPD_WR: begin
          v <= pv;
          steps <= steps + 1'b1;
        end
        default: ;
      endcase
    end
  end

endmodule

/* tb/tb_max_flow_edmonds_karp_core.sv */
// Testbench for max_flow_edmonds_karp_core: loads capacity entries and checks
// each max-flow result against a self-contained Edmonds-Karp predictor or typed answer.
// Depends on mfek_pkg and the core RTL.
`timescale 1ns / 1ps
module tb_max_flow_edmonds_karp_core;
  import mfek_pkg::*;

  localparam int WATCHDOG_LIMIT = 400000;
  localparam int DIR_ROWS = 16;
  localparam int RAND_ITEMS = 1000;
  localparam logic STAT_OK = 1'b0;
  localparam logic STAT_SAME_ENDS = 1'b1;

  logic                 clk;
  logic                 rst;
  logic                 start;
  logic                 busy;
  logic [VBITS-1:0]     from_vertex;
  logic [VBITS-1:0]     to_vertex;
  logic [CAP_BITS-1:0]  capacity;
  logic [VBITS-1:0]     source_vertex;
  logic [VBITS-1:0]     sink_vertex;
  logic                 last;
  logic                 done;
  logic [FLOW_BITS-1:0] max_flow;
  logic                 status;

  // One matrix entry plus run control; typed-in answer used when has_answer.
  typedef struct {
    logic [VBITS-1:0]     fv;
    logic [VBITS-1:0]     tv;
    logic [CAP_BITS-1:0]  cap;
    logic [VBITS-1:0]     src;
    logic [VBITS-1:0]     snk;
    logic                 lst;
    logic                 has_answer;
    logic [FLOW_BITS-1:0] ans_flow;
    logic                 ans_stat;
  } entry_item_t;

  typedef struct {
    logic [FLOW_BITS-1:0] flow;
    logic                 stat;
  } flow_result_t;

  entry_item_t          dir_rows[DIR_ROWS];
  flow_result_t         pending_flows[$];
  logic [CAP_BITS-1:0]  cap_matrix[VERTICES][VERTICES];
  int                   mismatches;
  int                   items_sent;
  int                   runs_checked;
  int                   same_end_runs;
  int                   stalled_cycles;

  max_flow_edmonds_karp_core uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .from_vertex(from_vertex), .to_vertex(to_vertex), .capacity(capacity),
    .source_vertex(source_vertex), .sink_vertex(sink_vertex), .last(last),
    .done(done), .max_flow(max_flow), .status(status)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Edmonds-Karp over the shadow matrix: BFS for shortest paths, push the
  // bottleneck, and accumulate until the sink is no longer reachable.
  function automatic longint solve_flow(input int src, input int snk);
    longint resid[VERTICES][VERTICES];
    bit     seen[VERTICES];
    int     parent[VERTICES];
    int     bfs_q[VERTICES];
    int     head;
    int     tail;
    int     u;
    int     v;
    int     steps;
    longint neck;
    longint total;
    total = 0;
    for (int r = 0; r < VERTICES; r++)
      for (int c = 0; c < VERTICES; c++)
        resid[r][c] = cap_matrix[r][c];
    forever begin
      for (int i = 0; i < VERTICES; i++) seen[i] = 1'b0;
      head = 0;
      tail = 0;
      bfs_q[tail++] = src;
      seen[src] = 1'b1;
      parent[src] = src;
      while (head < tail) begin
        u = bfs_q[head++];
        for (int w = 0; w < VERTICES; w++) begin
          if (!seen[w] && resid[u][w] > 0 && tail < VERTICES) begin
            bfs_q[tail++] = w;
            parent[w] = u;
            seen[w] = 1'b1;
          end
        end
      end
      if (!seen[snk]) break;
      // Walk back from the sink for the bottleneck, then update residuals.
      neck = 64'h7FFF_FFFF_FFFF_FFFF;
      v = snk;
      for (steps = 0; v != src && steps < VERTICES; steps++) begin
        u = parent[v];
        if (resid[u][v] < neck) neck = resid[u][v];
        v = u;
      end
      v = snk;
      for (steps = 0; v != src && steps < VERTICES; steps++) begin
        u = parent[v];
        resid[u][v] -= neck;
        resid[v][u] += neck;
        v = u;
      end
      total += neck;
    end
    return total;
  endfunction

  // Store the entry; on last, queue the expected flow result.
  task automatic predict_entry(input entry_item_t it);
    flow_result_t res;
    cap_matrix[it.fv][it.tv] = it.cap;
    if (it.lst) begin
      if (it.src == it.snk) begin
        res.flow = '0;
        res.stat = STAT_SAME_ENDS;
        same_end_runs++;
      end else begin
        res.flow = FLOW_BITS'(solve_flow(it.src, it.snk));
        res.stat = STAT_OK;
      end
      if (it.has_answer) begin
        res.flow = it.ans_flow;
        res.stat = it.ans_stat;
      end
      pending_flows.push_back(res);
    end
  endtask

  // Drive at the falling edge, wait for acceptance, then idle a random gap.
  task automatic send_entry(input entry_item_t it);
    int r;
    int gap;
    @(negedge clk);
    from_vertex   <= it.fv;
    to_vertex     <= it.tv;
    capacity      <= it.cap;
    source_vertex <= it.src;
    sink_vertex   <= it.snk;
    last          <= it.lst;
    start         <= 1'b1;
    do @(posedge clk); while (busy);
    predict_entry(it);
    items_sent++;
    r = $urandom_range(0, 99);
    if (r < 60) gap = 0;
    else if (r < 92) gap = $urandom_range(1, 3);
    else gap = $urandom_range(10, 40);
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  function automatic entry_item_t random_entry(input logic lst);
    entry_item_t it;
    int r;
    it.fv = VBITS'($urandom);
    it.tv = VBITS'($urandom);
    r = $urandom_range(0, 9);
    if (r < 5) it.cap = CAP_BITS'($urandom);
    else if (r < 8) it.cap = CAP_BITS'($urandom_range(1, 15));
    else it.cap = '0;
    it.src = VBITS'($urandom);
    it.snk = VBITS'($urandom);
    it.lst = lst;
    it.has_answer = 1'b0;
    it.ans_flow = '0;
    it.ans_stat = STAT_OK;
    return it;
  endfunction

  // Check each done pulse against the oldest pending result.
  always @(posedge clk) begin
    flow_result_t exp_res;
    if (!rst && done) begin
      if (pending_flows.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected result flow=%0d status=%0d", max_flow, status);
      end else begin
        exp_res = pending_flows.pop_front();
        runs_checked++;
        if (max_flow !== exp_res.flow || status !== exp_res.stat) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: run %0d expected flow=%0d status=%0d, got flow=%0d status=%0d",
                     runs_checked, exp_res.flow, exp_res.stat, max_flow, status);
        end
      end
    end
  end

  // Watchdog: count cycles with neither an accepted item nor a result.
  always @(posedge clk) begin
    if ((start && !busy) || done) stalled_cycles <= 0;
    else stalled_cycles <= stalled_cycles + 1;
    if (stalled_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout after %0d idle cycles", stalled_cycles);
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    entry_item_t it;
    int burst;
    bit paused;
    rst = 1'b1;
    start = 1'b0;
    from_vertex = '0;
    to_vertex = '0;
    capacity = '0;
    source_vertex = '0;
    sink_vertex = '0;
    last = 1'b0;
    mismatches = 0;
    items_sent = 0;
    runs_checked = 0;
    same_end_runs = 0;
    stalled_cycles = 0;
    paused = 1'b0;
    for (int r = 0; r < VERTICES; r++)
      for (int c = 0; c < VERTICES; c++)
        cap_matrix[r][c] = '0;

    // Directed table: fv tv cap src snk last | typed answer (flag flow stat).
    dir_rows[0]  = '{3'd0, 3'd7, 16'd0,     3'd0, 3'd7, 1'b1, 1'b1, 19'd0,     STAT_OK};
    dir_rows[1]  = '{3'd3, 3'd3, 16'd0,     3'd5, 3'd5, 1'b1, 1'b1, 19'd0,     STAT_SAME_ENDS};
    dir_rows[2]  = '{3'd0, 3'd7, 16'hFFFF,  3'd0, 3'd7, 1'b1, 1'b1, 19'd65535, STAT_OK};
    dir_rows[3]  = '{3'd7, 3'd0, 16'hFFFF,  3'd7, 3'd0, 1'b1, 1'b1, 19'd65535, STAT_OK};
    dir_rows[4]  = '{3'd7, 3'd7, 16'hFFFF,  3'd7, 3'd7, 1'b1, 1'b1, 19'd0,     STAT_SAME_ENDS};
    dir_rows[5]  = '{3'd0, 3'd7, 16'd0,     3'd0, 3'd0, 1'b0, 1'b0, 19'd0,     STAT_OK};
    dir_rows[6]  = '{3'd7, 3'd0, 16'd0,     3'd7, 3'd0, 1'b1, 1'b1, 19'd0,     STAT_OK};
    dir_rows[7]  = '{3'd0, 3'd1, 16'd100,   3'd0, 3'd0, 1'b0, 1'b0, 19'd0,     STAT_OK};
    dir_rows[8]  = '{3'd1, 3'd2, 16'd50,    3'd0, 3'd0, 1'b0, 1'b0, 19'd0,     STAT_OK};
    dir_rows[9]  = '{3'd2, 3'd7, 16'd80,    3'd0, 3'd7, 1'b1, 1'b0, 19'd0,     STAT_OK};
    dir_rows[10] = '{3'd0, 3'd3, 16'd30,    3'd0, 3'd0, 1'b0, 1'b0, 19'd0,     STAT_OK};
    dir_rows[11] = '{3'd3, 3'd2, 16'd40,    3'd0, 3'd0, 1'b0, 1'b0, 19'd0,     STAT_OK};
    dir_rows[12] = '{3'd3, 3'd7, 16'd25,    3'd0, 3'd7, 1'b1, 1'b0, 19'd0,     STAT_OK};
    dir_rows[13] = '{3'd2, 3'd1, 16'hFFFF,  3'd7, 3'd0, 1'b1, 1'b0, 19'd0,     STAT_OK};
    dir_rows[14] = '{3'd1, 3'd0, 16'hAAAA,  3'd2, 3'd0, 1'b1, 1'b0, 19'd0,     STAT_OK};
    dir_rows[15] = '{3'd5, 3'd6, 16'h5555,  3'd6, 3'd5, 1'b1, 1'b0, 19'd0,     STAT_OK};

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part; the core sweeps its matrix first, so start waits on busy.
    for (int i = 0; i < DIR_ROWS; i++) send_entry(dir_rows[i]);

    // Random part: mostly bursts of entries closed by a last item, some noise.
    while (items_sent < DIR_ROWS + RAND_ITEMS) begin
      if ($urandom_range(0, 99) < 85) begin
        burst = $urandom_range(1, 12);
        for (int k = 0; k < burst; k++) send_entry(random_entry(1'b0));
        it = random_entry(1'b1);
        // Keep most runs on distinct ends so the search does real work.
        if (it.src == it.snk && $urandom_range(0, 3) != 0) it.snk = it.src + 3'd1;
        send_entry(it);
      end else begin
        send_entry(random_entry(VBITS'($urandom_range(0, 1)) != 0));
      end
      // Halfway through, hold off until the core has drained every result.
      if (!paused && items_sent > DIR_ROWS + RAND_ITEMS / 2) begin
        paused = 1'b1;
        @(negedge clk);
        start <= 1'b0;
        while (pending_flows.size() != 0) @(posedge clk);
        repeat (20) @(negedge clk);
      end
    end

    @(negedge clk);
    start <= 1'b0;
    while (pending_flows.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);

    $display("Covered %0d items and %0d max-flow runs (%0d with source equal to sink)",
             items_sent, runs_checked, same_end_runs);
    $display("Mismatches: %0d", mismatches);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
